[design/kplc_pkg.sv]
// shared types, codes and constants for the keypad lock controller
`default_nettype none

package kplc_pkg;

   // field widths
   localparam int unsigned KEY_W     = 4;
   localparam int unsigned PIN_W     = 16;
   localparam int unsigned TICKS_W   = 16;
   localparam int unsigned LIMIT_W   = 4;
   localparam int unsigned COUNT_W   = 4;
   localparam int unsigned EVENT_W   = 5;
   localparam int unsigned RITEM_W   = 3;
   localparam int unsigned RVAL_W    = 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 16;
   localparam int unsigned REQ_DAT_W = 8;
   localparam int unsigned RSP_DAT_W = 24;

   // register reset values
   localparam logic [PIN_W-1:0]   USER_PIN_RST   = 16'h1234;
   localparam logic [PIN_W-1:0]   ADMIN_PIN_RST  = 16'h2345;
   localparam logic [TICKS_W-1:0] AUTO_LOCK_RST  = 16'd100;
   localparam logic [LIMIT_W-1:0] ATT_LIMIT_RST  = 4'd3;

   // command patterns, first key in the top nibble, star is key 14
   localparam logic [PIN_W-1:0] PAT_DISARM      = 16'hABCD;
   localparam logic [PIN_W-1:0] PAT_STATUS      = 16'hDCBA;
   localparam logic [PIN_W-1:0] PAT_ARM         = 16'hDEEE;
   localparam logic [PIN_W-1:0] PAT_DOOR_SHUT   = 16'hAEEE;
   localparam logic [PIN_W-1:0] PAT_GARAGE_SHUT = 16'hBEEE;
   localparam logic [PIN_W-1:0] PAT_LIGHTS      = 16'hCEEE;
   localparam logic [PIN_W-1:0] PAT_GARAGE_OPEN = 16'hEEEB;
   localparam logic [PIN_W-1:0] PAT_PASS        = 16'h5EEE;
   localparam logic [PIN_W-1:0] PAT_REP_DOOR    = 16'h1EEE;
   localparam logic [PIN_W-1:0] PAT_REP_LIGHTS  = 16'h2EEE;
   localparam logic [PIN_W-1:0] PAT_REP_ALARM   = 16'h3EEE;
   localparam logic [PIN_W-1:0] PAT_REP_GARAGE  = 16'h4EEE;

   localparam logic [KEY_W-1:0]   KEY_HASH       = 4'hF;
   localparam logic [1:0]         KEY_COUNT_LAST = 2'd3;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = 4'hF;
   localparam logic [TICKS_W-1:0] ELAPSED_MAX    = 16'hFFFF;

   typedef enum logic {
      OP_KEY  = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_USER_PIN   = 2'd0,
      CSR_ADMIN_PIN  = 2'd1,
      CSR_AUTO_LOCK  = 2'd2,
      CSR_ATT_LIMIT  = 2'd3
   } csr_idx_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE         = 5'd0,
      EV_BUFFERED     = 5'd1,
      EV_CLEARED      = 5'd2,
      EV_DISARMED     = 5'd3,
      EV_STATUS_ON    = 5'd4,
      EV_ARMED        = 5'd5,
      EV_DOOR_SHUT    = 5'd6,
      EV_GARAGE_SHUT  = 5'd7,
      EV_LIGHTS       = 5'd8,
      EV_GARAGE_OPEN  = 5'd9,
      EV_PASS_PROMPT  = 5'd10,
      EV_WELCOME      = 5'd11,
      EV_WRONG_PIN    = 5'd12,
      EV_ALARM        = 5'd13,
      EV_REPORT       = 5'd14,
      EV_AUTO_LOCKED  = 5'd15,
      EV_DISCARD      = 5'd16
   } event_type;

   typedef enum logic [RITEM_W-1:0] {
      RI_NONE   = 3'd0,
      RI_DOOR   = 3'd1,
      RI_LIGHTS = 3'd2,
      RI_ALARM  = 3'd3,
      RI_GARAGE = 3'd4
   } ritem_type;

   typedef enum logic [RVAL_W-1:0] {
      RV_OFF   = 2'd0,
      RV_ON    = 2'd1,
      RV_ALARM = 2'd2
   } rval_type;

   // one accepted input item
   typedef struct packed {
      op_type           op;
      logic [KEY_W-1:0] key_code;
   } req_item_type;

   // one result item
   typedef struct packed {
      event_type          event_res;
      ritem_type          report_item;
      rval_type           report_value;
      logic               door_open;
      logic               garage_open;
      logic               lights_on;
      logic               led_on;
      logic               alarm_armed;
      logic               alarm_active;
      logic [COUNT_W-1:0] attempts;
   } rsp_item_type;

   // configuration write
   typedef struct packed {
      logic                 we;
      csr_idx_type          idx;
      logic [CSR_DAT_W-1:0] wdata;
   } csr_wr_type;

endpackage

`default_nettype wire

[design/kplc_inbuf.sv]
// input register that holds one accepted item for the decision stage
`default_nettype none

module kplc_inbuf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire kplc_pkg::req_item_type in_item,
   output logic                       item_valid,
   input  wire logic                  item_take,
   output kplc_pkg::req_item_type     item
);
   import kplc_pkg::*;

   logic         vld_ff;
   logic         vld_in;
   req_item_type item_ff;

   // slot is free when empty or drained this cycle
   assign in_ready   = !vld_ff || item_take;
   assign vld_in     = (in_valid && in_ready) || (vld_ff && !item_take);
   assign item_valid = vld_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload capture on transfer
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

[design/kplc_core.sv]
// lock state, configuration registers and the per-item decision logic
`default_nettype none

module kplc_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire kplc_pkg::csr_wr_type   csr,
   input  wire logic                   step,
   input  wire kplc_pkg::req_item_type item,
   output kplc_pkg::rsp_item_type      result
);
   import kplc_pkg::*;

   // configuration registers
   logic [PIN_W-1:0]   user_pin_ff;
   logic [PIN_W-1:0]   admin_pin_ff;
   logic [TICKS_W-1:0] auto_lock_ff;
   logic [LIMIT_W-1:0] att_limit_ff;

   // lock state
   logic [PIN_W-1:0]   key_buffer_ff, key_buffer_in;
   logic [1:0]         key_count_ff, key_count_in;
   logic               status_ff, status_in;
   logic               door_ff, door_in;
   logic               garage_ff, garage_in;
   logic               lights_ff, lights_in;
   logic               led_ff, led_in;
   logic               armed_ff, armed_in;
   logic               trig_ff, trig_in;
   logic [COUNT_W-1:0] wrong_ff, wrong_in;
   logic [TICKS_W-1:0] elapsed_ff, elapsed_in;

   logic [PIN_W-1:0]   full_buf;
   logic [TICKS_W-1:0] elapsed_inc;
   logic [COUNT_W-1:0] wrong_inc;
   event_type          ev;
   ritem_type          ritem;
   rval_type           rval;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         user_pin_ff  <= USER_PIN_RST;
         admin_pin_ff <= ADMIN_PIN_RST;
         auto_lock_ff <= AUTO_LOCK_RST;
         att_limit_ff <= ATT_LIMIT_RST;
      end else if (csr.we) begin
         unique case (csr.idx)
            CSR_USER_PIN:  user_pin_ff  <= csr.wdata;
            CSR_ADMIN_PIN: admin_pin_ff <= csr.wdata;
            CSR_AUTO_LOCK: auto_lock_ff <= csr.wdata;
            CSR_ATT_LIMIT: att_limit_ff <= csr.wdata[LIMIT_W-1:0];
            default:       user_pin_ff  <= user_pin_ff;
         endcase
      end
   end

   // next state and event for one key or tick
   always_comb begin
      full_buf      = {key_buffer_ff[PIN_W-KEY_W-1:0], item.key_code};
      elapsed_inc   = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
      wrong_inc     = (wrong_ff == COUNT_MAX) ? wrong_ff : wrong_ff + 1'b1;
      key_buffer_in = key_buffer_ff;
      key_count_in  = key_count_ff;
      status_in     = status_ff;
      door_in       = door_ff;
      garage_in     = garage_ff;
      lights_in     = lights_ff;
      led_in        = led_ff;
      armed_in      = armed_ff;
      trig_in       = trig_ff;
      wrong_in      = wrong_ff;
      elapsed_in    = elapsed_ff;
      ev            = EV_NONE;
      ritem         = RI_NONE;
      rval          = RV_OFF;

      if (item.op == OP_TICK) begin
         // auto-close timer
         if (door_ff || garage_ff) begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc >= auto_lock_ff) begin
               door_in   = 1'b0;
               garage_in = 1'b0;
               ev        = EV_AUTO_LOCKED;
            end
         end
      end else if (item.key_code == KEY_HASH) begin
         key_buffer_in = '0;
         key_count_in  = '0;
         status_in     = 1'b0;
         ev            = EV_CLEARED;
      end else if (key_count_ff != KEY_COUNT_LAST) begin
         key_buffer_in = full_buf;
         key_count_in  = key_count_ff + 1'b1;
         ev            = EV_BUFFERED;
      end else begin
         key_buffer_in = '0;
         key_count_in  = '0;
         if (status_ff) begin
            // status mode queries
            priority if (full_buf == PAT_REP_DOOR) begin
               ritem = RI_DOOR;
               rval  = door_ff ? RV_ON : RV_OFF;
            end else if (full_buf == PAT_REP_LIGHTS) begin
               ritem = RI_LIGHTS;
               rval  = lights_ff ? RV_ON : RV_OFF;
            end else if (full_buf == PAT_REP_ALARM) begin
               ritem = RI_ALARM;
               rval  = trig_ff ? RV_ALARM : (armed_ff ? RV_ON : RV_OFF);
            end else if (full_buf == PAT_REP_GARAGE) begin
               ritem = RI_GARAGE;
               rval  = garage_ff ? RV_ON : RV_OFF;
            end else begin
               ritem = RI_NONE;
            end
            if (ritem != RI_NONE) begin
               status_in = 1'b0;
               ev        = EV_REPORT;
            end else begin
               ev = EV_DISCARD;
            end
         end else begin
            // commands first, then the pin check
            priority if (full_buf == PAT_DISARM) begin
               armed_in = 1'b0;
               trig_in  = 1'b0;
               wrong_in = '0;
               led_in   = 1'b0;
               ev       = EV_DISARMED;
            end else if (full_buf == PAT_STATUS) begin
               status_in = 1'b1;
               ev        = EV_STATUS_ON;
            end else if (full_buf == PAT_ARM) begin
               armed_in = 1'b1;
               ev       = EV_ARMED;
            end else if (full_buf == PAT_DOOR_SHUT) begin
               door_in = 1'b0;
               ev      = EV_DOOR_SHUT;
            end else if (full_buf == PAT_GARAGE_SHUT) begin
               garage_in = 1'b0;
               ev        = EV_GARAGE_SHUT;
            end else if (full_buf == PAT_LIGHTS) begin
               lights_in = !lights_ff;
               led_in    = !lights_ff;
               ev        = EV_LIGHTS;
            end else if (full_buf == PAT_GARAGE_OPEN) begin
               garage_in  = 1'b1;
               elapsed_in = '0;
               ev         = EV_GARAGE_OPEN;
            end else if (full_buf == PAT_PASS) begin
               ev = EV_PASS_PROMPT;
            end else if (full_buf == user_pin_ff || full_buf == admin_pin_ff) begin
               wrong_in   = '0;
               trig_in    = 1'b0;
               door_in    = 1'b1;
               elapsed_in = '0;
               if (full_buf != user_pin_ff) begin
                  garage_in = 1'b1;
               end
               ev = EV_WELCOME;
            end else begin
               wrong_in = wrong_inc;
               if (armed_ff && (wrong_inc >= att_limit_ff)) begin
                  trig_in = 1'b1;
                  ev      = EV_ALARM;
               end else begin
                  ev = EV_WRONG_PIN;
               end
            end
         end
      end

      // a triggered alarm keeps the led lit
      if (trig_in) begin
         led_in = 1'b1;
      end
   end

   // state update once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         key_buffer_ff <= '0;
         key_count_ff  <= '0;
         status_ff     <= 1'b0;
         door_ff       <= 1'b0;
         garage_ff     <= 1'b0;
         lights_ff     <= 1'b0;
         led_ff        <= 1'b0;
         armed_ff      <= 1'b0;
         trig_ff       <= 1'b0;
         wrong_ff      <= '0;
         elapsed_ff    <= '0;
      end else if (step) begin
         key_buffer_ff <= key_buffer_in;
         key_count_ff  <= key_count_in;
         status_ff     <= status_in;
         door_ff       <= door_in;
         garage_ff     <= garage_in;
         lights_ff     <= lights_in;
         led_ff        <= led_in;
         armed_ff      <= armed_in;
         trig_ff       <= trig_in;
         wrong_ff      <= wrong_in;
         elapsed_ff    <= elapsed_in;
      end
   end

   // result built from the post-step state
   assign result.event_res    = ev;
   assign result.report_item  = ritem;
   assign result.report_value = rval;
   assign result.door_open    = door_in;
   assign result.garage_open  = garage_in;
   assign result.lights_on    = lights_in;
   assign result.led_on       = led_in;
   assign result.alarm_armed  = armed_in;
   assign result.alarm_active = trig_in;
   assign result.attempts     = wrong_in;

endmodule

`default_nettype wire

[design/kplc_outbuf.sv]
// result register that holds one result until the consumer takes it
`default_nettype none

module kplc_outbuf (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   output logic                        load_ready,
   input  wire kplc_pkg::rsp_item_type load_item,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output kplc_pkg::rsp_item_type      out_item
);
   import kplc_pkg::*;

   logic         vld_ff;
   logic         vld_in;
   rsp_item_type item_ff;

   // free when empty or its result leaves this cycle
   assign load_ready = !vld_ff || out_ready;
   assign vld_in     = load || (vld_ff && !out_ready);
   assign out_valid  = vld_ff;
   assign out_item   = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

endmodule

`default_nettype wire

[design/keypad_lock_controller.sv]
// keypad combination lock: input register, decision logic, result register
//
//  channel  | ports         | contents
//  ---------+---------------+------------------------------------------------
//  request  | req_t*        | tuser[0] op (key or tick), tdata[3:0] key code
//  response | rsp_t*        | tdata: event, report item/value, outputs, count
//  config   | csr_*         | csr_addr selects register, csr_wdata value
//
// Each item passes through the input register, then the combinational
// decision logic, and is held in the result register until it is taken.
// One item is accepted per cycle while the response is not stalled; the lock
// state is updated as each item leaves the input register.
// Reset is synchronous and clears both registers' valid bits and the state.
// A stalled response holds its result and stops the decision stage, and the
// input register then fills and drops req_tready.
`default_nettype none

module keypad_lock_controller (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [3:0] key_code, [7:4] zero
   input  wire logic [kplc_pkg::REQ_DAT_W-1:0]  req_tdata,
   // [0] op
   input  wire logic [0:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [4:0] event_res, [7:5] report_item, [9:8] report_value, [10] door_open,
   // [11] garage_open, [12] lights_on, [13] led_on, [14] alarm_armed,
   // [15] alarm_active, [19:16] attempts, [23:20] zero
   output logic [kplc_pkg::RSP_DAT_W-1:0]       rsp_tdata,
   input  wire logic                            csr_we,
   input  wire logic [kplc_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  wire logic [kplc_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import kplc_pkg::*;

   req_item_type in_item;
   req_item_type item;
   rsp_item_type result;
   rsp_item_type out_item;
   csr_wr_type   csr;
   logic         item_valid;
   logic         load_ready;
   logic         step;

   assign in_item.op       = op_type'(req_tuser[0]);
   assign in_item.key_code = req_tdata[KEY_W-1:0];

   assign csr.we    = csr_we;
   assign csr.idx   = csr_idx_type'(csr_addr);
   assign csr.wdata = csr_wdata;

   // decision stage advances when the result register can take it
   assign step = item_valid && load_ready;

   kplc_inbuf u_inbuf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item_take  (step),
      .item       (item)
   );

   kplc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .step   (step),
      .item   (item),
      .result (result)
   );

   kplc_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .load_ready (load_ready),
      .load_item  (result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (out_item)
   );

   // pack the result, first field in the low bits
   assign rsp_tdata = {4'b0000,
                       out_item.attempts,
                       out_item.alarm_active,
                       out_item.alarm_armed,
                       out_item.led_on,
                       out_item.lights_on,
                       out_item.garage_open,
                       out_item.door_open,
                       out_item.report_value,
                       out_item.report_item,
                       out_item.event_res};

endmodule

`default_nettype wire

[design/kplc_checker.sv]
// port-level checks on the keypad lock controller, bound to the top level
`default_nettype none

module kplc_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [kplc_pkg::RSP_DAT_W-1:0]  rsp_tdata
);
   import kplc_pkg::*;

   // a stalled response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // report fields are set only on a report event
   a_report_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[4:0] == EV_REPORT) ==
                      (rsp_tdata[7:5] != RI_NONE))
                     && ((rsp_tdata[4:0] == EV_REPORT) || (rsp_tdata[9:8] == RV_OFF)))
      else $error("report fields out of step with event");

   // an active alarm always lights the led
   a_alarm_led: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15] |-> rsp_tdata[13])
      else $error("alarm active without led");

   // disarm leaves the alarm fully cleared
   a_disarm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[4:0] == EV_DISARMED) |->
         !rsp_tdata[14] && !rsp_tdata[15] && !rsp_tdata[13] && (rsp_tdata[19:16] == 4'd0))
      else $error("disarm left alarm state behind");

   // auto lock closes door and garage
   a_auto_lock: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[4:0] == EV_AUTO_LOCKED) |-> !rsp_tdata[10] && !rsp_tdata[11])
      else $error("auto lock left an opening");

endmodule

bind keypad_lock_controller kplc_checker u_kplc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
